>>> src/sdoc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_pkg: shared types and constants for the SDO expedited client
// Holds the command and result codes, the protocol constants and the
// item structures passed between the client's modules.
// ----------------------------------------------------------------------------
package sdoc_pkg;

	// command codes of an input item
	typedef enum logic [1:0] {
		CMD_START_WRITE = 2'd0,
		CMD_START_READ  = 2'd1,
		CMD_RX_FRAME    = 2'd2,
		CMD_TICK        = 2'd3
	} cmd_t;

	// kinds of a result item
	typedef enum logic [1:0] {
		KIND_TX_REQUEST = 2'd0,
		KIND_DONE       = 2'd1,
		KIND_FAILED     = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic REG_TIMEOUT_TICKS = 1'b0;
	localparam logic REG_WRITE_TRIES   = 1'b1;

	localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd5;
	localparam logic [2:0] WRITE_TRIES_RESET   = 3'd3;

	// COB-ID bases
	localparam logic [10:0] SDO_TX_BASE = 11'h600;
	localparam logic [10:0] SDO_RX_BASE = 11'h580;

	// SDO command specifier bytes
	localparam logic [7:0] CS_WRITE4 = 8'h23;
	localparam logic [7:0] CS_WRITE3 = 8'h27;
	localparam logic [7:0] CS_WRITE2 = 8'h2b;
	localparam logic [7:0] CS_WRITE1 = 8'h2f;
	localparam logic [7:0] CS_READ   = 8'h40;

	localparam logic [7:0] TICK_MAX = 8'd255;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 112;

	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [2:0] write_tries;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [6:0]  node_id;
		logic [15:0] obj_index;
		logic [7:0]  obj_subindex;
		logic [2:0]  data_len;
		logic [31:0] write_value;
		logic [10:0] rx_cob_id;
		logic [15:0] rx_index;
		logic [31:0] rx_value;
	} in_item_t;

	typedef struct packed {
		kind_t       out_kind;
		logic [10:0] tx_cob_id;
		logic [7:0]  tx_command_byte;
		logic [15:0] tx_index;
		logic [7:0]  tx_subindex;
		logic [31:0] tx_data;
		logic [31:0] answer_value;
	} out_item_t;

endpackage : sdoc_pkg
`default_nettype wire

>>> src/sdo_expedited_client.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdo_expedited_client: CANopen SDO expedited client
// Issues expedited SDO write and read requests, matches replies, and
// handles timeouts with resends for writes.
//
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       s_tdata, s_tuser = command
// m_*       out        m_tvalid / m_tready       m_tdata, m_tuser = out_kind
// apb       in         psel & penable & pwrite   paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; each item
// passes the input register, then decision logic into the result register.
// Reset clears the transaction state and the valid flags of both registers;
// the configuration registers return to 5 ticks and 3 write tries.
// A stalled result holds the input register, and s_tready drops only then.
// ----------------------------------------------------------------------------
module sdo_expedited_client
	import sdoc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// request stream in
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// node_id[6:0], obj_index[22:7], obj_subindex[30:23], data_len[33:31],
	// write_value[65:34], rx_cob_id[76:66], rx_index[92:77], rx_value[124:93]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  wire logic [1:0]            s_tuser,
	// result stream out
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// tx_cob_id[10:0], tx_command_byte[18:11], tx_index[34:19],
	// tx_subindex[42:35], tx_data[74:43], answer_value[106:75]
	output logic      [OUT_DATA_W-1:0] m_tdata,
	// out_kind[1:0]
	output logic      [1:0]            m_tuser
);

	cfg_t      cfg;
	in_item_t  item_in;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      step;
	logic      res_valid;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;

	sdoc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// unpack the incoming request
	assign item_in.command      = cmd_t'(s_tuser);
	assign item_in.node_id      = s_tdata[6:0];
	assign item_in.obj_index    = s_tdata[22:7];
	assign item_in.obj_subindex = s_tdata[30:23];
	assign item_in.data_len     = s_tdata[33:31];
	assign item_in.write_value  = s_tdata[65:34];
	assign item_in.rx_cob_id    = s_tdata[76:66];
	assign item_in.rx_index     = s_tdata[92:77];
	assign item_in.rx_value     = s_tdata[124:93];

	// the held item moves on when the result register can take its result
	assign step     = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	sdoc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= step & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	// pack the outgoing result
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.out_kind;
	assign m_tdata  = {5'd0, res_s2.answer_value, res_s2.tx_data, res_s2.tx_subindex,
		res_s2.tx_index, res_s2.tx_command_byte, res_s2.tx_cob_id};

endmodule : sdo_expedited_client
`default_nettype wire

>>> src/sdoc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_regs: configuration registers
// APB-style port with the timeout and write try registers; zero wait states.
// ----------------------------------------------------------------------------
module sdoc_regs
	import sdoc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [7:0] timeout_ticks_q;
	logic [2:0] write_tries_q;
	logic       wr_en;
	logic       addr_ok;

	assign pready  = 1'b1;
	assign addr_ok = (paddr[1:0] == 2'b00);
	assign wr_en   = psel & penable & pwrite & pready & addr_ok;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_TICKS_RESET;
			write_tries_q   <= WRITE_TRIES_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[7:0];
				REG_WRITE_TRIES:   write_tries_q   <= pwdata[2:0];
				default:           ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (addr_ok) begin
			unique case (paddr[2])
				REG_TIMEOUT_TICKS: prdata = {24'd0, timeout_ticks_q};
				REG_WRITE_TRIES:   prdata = {29'd0, write_tries_q};
				default:           prdata = '0;
			endcase
		end
	end

	assign cfg.timeout_ticks = timeout_ticks_q;
	assign cfg.write_tries   = write_tries_q;

endmodule : sdoc_regs
`default_nettype wire

>>> src/sdoc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_core: transaction state and per-item decision logic
// Holds the transaction registers and works out, for one registered item,
// the next state and the result it gives, if any.
// ----------------------------------------------------------------------------
module sdoc_core
	import sdoc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      res_valid,
	output out_item_t res
);

	logic        busy_q,        busy_d;
	logic        is_write_q,    is_write_d;
	logic [6:0]  node_q,        node_d;
	logic [15:0] index_q,       index_d;
	logic [7:0]  subindex_q,    subindex_d;
	logic [7:0]  cmd_byte_q,    cmd_byte_d;
	logic [31:0] value_q,       value_d;
	logic [7:0]  tick_count_q,  tick_count_d;
	logic [2:0]  tries_left_q,  tries_left_d;

	logic        rx_match;
	logic        emit_req;
	logic [7:0]  tick_inc;
	logic [7:0]  len_byte;

	// request frame from the (next) held transaction
	function automatic out_item_t build_request(
		input logic [6:0]  node,
		input logic [7:0]  cmd_byte,
		input logic [15:0] idx,
		input logic [7:0]  sub,
		input logic        wr,
		input logic [31:0] value
	);
		out_item_t r;
		r                 = '0;
		r.out_kind        = KIND_TX_REQUEST;
		r.tx_cob_id       = SDO_TX_BASE + {4'd0, node};
		r.tx_command_byte = cmd_byte;
		r.tx_index        = idx;
		r.tx_subindex     = sub;
		r.tx_data         = wr ? value : 32'd0;
		return r;
	endfunction

	assign rx_match = (item.rx_cob_id == (SDO_RX_BASE + {4'd0, node_q}))
		&& (item.rx_index == index_q);
	assign tick_inc = (tick_count_q < TICK_MAX) ? (tick_count_q + 8'd1) : tick_count_q;

	// command byte by write length
	always_comb begin
		unique case (item.data_len)
			3'd4:    len_byte = CS_WRITE4;
			3'd3:    len_byte = CS_WRITE3;
			3'd2:    len_byte = CS_WRITE2;
			default: len_byte = CS_WRITE1;
		endcase
	end

	// next state
	always_comb begin
		busy_d       = busy_q;
		is_write_d   = is_write_q;
		node_d       = node_q;
		index_d      = index_q;
		subindex_d   = subindex_q;
		cmd_byte_d   = cmd_byte_q;
		value_d      = value_q;
		tick_count_d = tick_count_q;
		tries_left_d = tries_left_q;
		emit_req     = 1'b0;
		res_valid    = 1'b0;
		res          = '0;
		unique case (item.command)
			CMD_START_WRITE, CMD_START_READ: begin
				node_d       = item.node_id;
				index_d      = item.obj_index;
				subindex_d   = item.obj_subindex;
				tick_count_d = '0;
				busy_d       = 1'b1;
				emit_req     = 1'b1;
				if (item.command == CMD_START_WRITE) begin
					is_write_d   = 1'b1;
					value_d      = item.write_value;
					cmd_byte_d   = len_byte;
					tries_left_d = (cfg.write_tries == 3'd0) ? 3'd0
						: (cfg.write_tries - 3'd1);
				end else begin
					is_write_d   = 1'b0;
					value_d      = '0;
					cmd_byte_d   = CS_READ;
					tries_left_d = '0;
				end
			end
			CMD_RX_FRAME: begin
				if (busy_q && rx_match) begin
					busy_d           = 1'b0;
					res_valid        = 1'b1;
					res.out_kind     = KIND_DONE;
					res.answer_value = item.rx_value;
				end
			end
			CMD_TICK: begin
				if (busy_q) begin
					tick_count_d = tick_inc;
					if (tick_inc >= cfg.timeout_ticks) begin
						if (tries_left_q != 3'd0) begin
							tries_left_d = tries_left_q - 3'd1;
							tick_count_d = '0;
							emit_req     = 1'b1;
						end else begin
							busy_d       = 1'b0;
							res_valid    = 1'b1;
							res.out_kind = KIND_FAILED;
						end
					end
				end
			end
			default: ;
		endcase
		if (emit_req) begin
			res_valid = 1'b1;
			res = build_request(node_d, cmd_byte_d, index_d, subindex_d,
				is_write_d, value_d);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			is_write_q   <= 1'b0;
			tick_count_q <= '0;
			tries_left_q <= '0;
			node_q       <= '0;
			index_q      <= '0;
			subindex_q   <= '0;
			cmd_byte_q   <= '0;
			value_q      <= '0;
		end else if (step) begin
			busy_q       <= busy_d;
			is_write_q   <= is_write_d;
			tick_count_q <= tick_count_d;
			tries_left_q <= tries_left_d;
			node_q       <= node_d;
			index_q      <= index_d;
			subindex_q   <= subindex_d;
			cmd_byte_q   <= cmd_byte_d;
			value_q      <= value_d;
		end
	end

endmodule : sdoc_core
`default_nettype wire
